[hdl/sdsc_pkg.sv]
// Shared types, codes and table helpers for the SPN differential subkey counter.
// No dependencies; used by sdsc_eval and the top level through scoped names.
package sdsc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_NIBBLE_SEL_A  = 2'd0;
  localparam logic [1:0] REG_NIBBLE_SEL_B  = 2'd1;
  localparam logic [1:0] REG_TARGET_DIFF_A = 2'd2;
  localparam logic [1:0] REG_TARGET_DIFF_B = 2'd3;

  localparam logic [1:0] NIBBLE_SEL_A_RST  = 2'd1;
  localparam logic [1:0] NIBBLE_SEL_B_RST  = 2'd3;
  localparam logic [3:0] TARGET_DIFF_RST   = 4'h6;

  localparam int unsigned NUM_CAND  = 256;
  localparam int unsigned CAND_BITS = 8;

  // Ciphertext nibbles of one pair at the two selected positions
  typedef struct packed {
    logic [3:0] ya;
    logic [3:0] yb;
    logic [3:0] za;
    logic [3:0] zb;
  } pair_nib_t;

  // Expected differences after the inverse S-box
  typedef struct packed {
    logic [3:0] tda;
    logic [3:0] tdb;
  } target_t;

  function automatic logic [3:0] sbox_inv(input logic [3:0] v);
    logic [3:0] r;
    case (v)
      4'h0:    r = 4'd14;
      4'h1:    r = 4'd3;
      4'h2:    r = 4'd4;
      4'h3:    r = 4'd8;
      4'h4:    r = 4'd1;
      4'h5:    r = 4'd12;
      4'h6:    r = 4'd10;
      4'h7:    r = 4'd15;
      4'h8:    r = 4'd7;
      4'h9:    r = 4'd13;
      4'hA:    r = 4'd9;
      4'hB:    r = 4'd6;
      4'hC:    r = 4'd11;
      4'hD:    r = 4'd2;
      4'hE:    r = 4'd0;
      4'hF:    r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Position 0 is the most significant nibble
  function automatic logic [3:0] nib_get(input logic [15:0] w, input logic [1:0] sel);
    logic [3:0] r;
    case (sel)
      2'd0:    r = w[15:12];
      2'd1:    r = w[11:8];
      2'd2:    r = w[7:4];
      2'd3:    r = w[3:0];
      default: r = w[3:0];
    endcase
    return r;
  endfunction

endpackage

[hdl/sdsc_eval.sv]
// Shared candidate unit: match test, saturating count update and max compare.
// Depends on sdsc_pkg.
module sdsc_eval #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic [sdsc_pkg::CAND_BITS-1:0] cand,
  input  sdsc_pkg::pair_nib_t            nib,
  input  sdsc_pkg::target_t              tgt,
  input  logic [COUNT_BITS-1:0]          count,
  input  logic [COUNT_BITS-1:0]          best_val,
  output logic [COUNT_BITS-1:0]          count_upd,
  output logic                           better
);

  logic [3:0] ka;
  logic [3:0] kb;
  logic [3:0] da;
  logic [3:0] db;
  logic       hit;

  assign ka = cand[7:4];
  assign kb = cand[3:0];
  assign da = sdsc_pkg::sbox_inv(nib.ya ^ ka) ^ sdsc_pkg::sbox_inv(nib.za ^ ka);
  assign db = sdsc_pkg::sbox_inv(nib.yb ^ kb) ^ sdsc_pkg::sbox_inv(nib.zb ^ kb);
  assign hit = (da == tgt.tda) && (db == tgt.tdb);

  // hold at full scale
  assign count_upd = (hit && (count != {COUNT_BITS{1'b1}})) ? count + COUNT_BITS'(1) : count;

  // first candidate always seeds the running max; ties keep the earlier one
  assign better = (cand == '0) || (count_upd > best_val);

endmodule

[hdl/sdsc_cnt_mem.sv]
// Candidate counter memory: one write port, one read port, registered read data.
// No dependencies.
module sdsc_cnt_mem #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [7:0]            waddr,
  input  logic [COUNT_BITS-1:0] wdata,
  input  logic [7:0]            raddr,
  output logic [COUNT_BITS-1:0] rdata
);

  logic [COUNT_BITS-1:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/spn_differential_subkey_counter.sv]
// Top level of the SPN differential subkey counter: sequencer, config registers,
// pair tally and output register. Depends on sdsc_pkg, sdsc_eval, sdsc_cnt_mem.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  in_      | slave     | ciphertext, paired_ciphertext in tdata; last_pair on tlast
//  out_     | master    | best_key_a, best_key_b, best_count, pairs_used in tdata
//  cfg_     | slave     | register index and write data, always ready
//
// Each pair holds in_tready low after its beat: the 256 candidate counters are read,
// updated and written back one per cycle through the counter memory, followed by a
// drain state and a finish state, so a new pair is accepted only once the previous
// one has finished. A last pair also clears the counters in the same sweep. A
// finished result waits in the output register; the next pair is accepted meanwhile,
// and only a following last pair stalls at its finish state until the result is taken.
// After reset a clearing pass over all 256 counters precedes the first accepted pair.
module spn_differential_subkey_counter #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] ciphertext, [31:16] paired_ciphertext
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] best_key_a, [7:4] best_key_b,
                                  // [23:8] best_count, [39:24] pairs_used
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int unsigned WB = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [7:0]            addr_r;
  logic [7:0]            addr_d_r;
  logic                  vld_d_r;
  logic                  last_r;
  sdsc_pkg::pair_nib_t   nib_r;
  logic [1:0]            sel_a_r;
  logic [1:0]            sel_b_r;
  sdsc_pkg::target_t     tgt_r;
  logic [15:0]           tally_r;
  logic [COUNT_BITS-1:0] best_val_r;
  logic [7:0]            best_idx_r;
  logic                  out_tvalid_r;
  logic [39:0]           out_tdata_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  mem_we;
  logic [7:0]            mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] count_upd;
  logic                  better;
  logic [WB-1:0]         best_ext;
  logic [15:0]           best_sat;
  logic [15:0]           ct0;
  logic [15:0]           ct1;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign ct0        = in_tdata[15:0];
  assign ct1        = in_tdata[31:16];

  assign best_ext = WB'(best_val_r);
  assign best_sat = (best_ext > WB'(17'h0FFFF)) ? 16'hFFFF : best_ext[15:0];

  // Clearing pass writes zeros; a sweep writes back one stage behind the read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_d_r;
    mem_wdata = '0;
    if (state_r == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
    end else if (vld_d_r) begin
      mem_we    = 1'b1;
      mem_wdata = last_r ? '0 : count_upd;
    end
  end

  sdsc_cnt_mem #(.COUNT_BITS(COUNT_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  sdsc_eval #(.COUNT_BITS(COUNT_BITS)) u_eval (
    .cand      (addr_d_r),
    .nib       (nib_r),
    .tgt       (tgt_r),
    .count     (mem_rdata),
    .best_val  (best_val_r),
    .count_upd (count_upd),
    .better    (better)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      addr_r       <= '0;
      vld_d_r      <= 1'b0;
      tally_r      <= '0;
      out_tvalid_r <= 1'b0;
      sel_a_r      <= sdsc_pkg::NIBBLE_SEL_A_RST;
      sel_b_r      <= sdsc_pkg::NIBBLE_SEL_B_RST;
      tgt_r.tda    <= sdsc_pkg::TARGET_DIFF_RST;
      tgt_r.tdb    <= sdsc_pkg::TARGET_DIFF_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdsc_pkg::REG_NIBBLE_SEL_A:  sel_a_r   <= cfg_data[1:0];
          sdsc_pkg::REG_NIBBLE_SEL_B:  sel_b_r   <= cfg_data[1:0];
          sdsc_pkg::REG_TARGET_DIFF_A: tgt_r.tda <= cfg_data;
          sdsc_pkg::REG_TARGET_DIFF_B: tgt_r.tdb <= cfg_data;
          default: ;
        endcase
      end

      // load a new result beat, else drop the one just taken
      if ((state_r == ST_DONE) && last_r && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      addr_d_r <= addr_r;
      vld_d_r  <= (state_r == ST_SWEEP);

      if (vld_d_r && better) begin
        best_val_r <= count_upd;
        best_idx_r <= addr_d_r;
      end

      case (state_r)
        ST_CLR: begin
          addr_r <= addr_r + 8'd1;
          if (addr_r == 8'hFF) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            nib_r.ya <= sdsc_pkg::nib_get(ct0, sel_a_r);
            nib_r.yb <= sdsc_pkg::nib_get(ct0, sel_b_r);
            nib_r.za <= sdsc_pkg::nib_get(ct1, sel_a_r);
            nib_r.zb <= sdsc_pkg::nib_get(ct1, sel_b_r);
            last_r   <= in_tlast;
            if (tally_r != 16'hFFFF) begin
              tally_r <= tally_r + 16'd1;
            end
            addr_r  <= '0;
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          addr_r <= addr_r + 8'd1;
          if (addr_r == 8'hFF) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_tdata_r  <= {tally_r, best_sat, best_idx_r[3:0], best_idx_r[7:4]};
            tally_r      <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
